// ===== rtl/kdtr_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed detection table ranker package
// Command and status codes, and the controller to datapath interface types.
// ----------------------------------------------------------------------------
package kdtr_pkg;

    localparam int MAC_W   = 48;
    localparam int CH_W    = 8;
    localparam int RSSI_W  = 8;
    localparam int DET_W   = 2;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    localparam int RANK_W  = 6;
    localparam int TOTAL_W = 7;

    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_REPORT = 7'b0000100,
        S_FETCH  = 7'b0001000,
        S_ENTRY  = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_EMPTY  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load_item;
        logic scan_start;
        logic scan_step;
        logic emit_report;
        logic emit_clear;
        logic emit_empty;
        logic emit_entry;
        logic next_rank;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic mode_list;
        logic table_empty;
        logic last_rank;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/kdtr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Keyed detection table ranker controller
// Sequences the table scans, entry fetches and result loads for each request.
// ----------------------------------------------------------------------------
module kdtr_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [1:0]               i_cmd,
    input  kdtr_pkg::t_dp_sts        i_sts,
    output kdtr_pkg::t_dp_cmd        o_cmd,
    output logic                     o_in_stall
);
    import kdtr_pkg::*;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    case (i_cmd)
                        CMD_REPORT: begin
                            o_cmd.scan_start = 1'b1;
                            n_state = S_SCAN;
                        end
                        CMD_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        CMD_LIST: begin
                            o_cmd.scan_start = 1'b1;
                            n_state = i_sts.table_empty ? S_EMPTY : S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = i_sts.mode_list ? S_FETCH : S_REPORT;
                end
            end
            S_REPORT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_report = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FETCH: begin
                n_state = S_ENTRY;
            end
            S_ENTRY: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_entry = 1'b1;
                    if (i_sts.last_rank) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next_rank  = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_CLEAR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_clear = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/kdtr_dp.sv =====
// ----------------------------------------------------------------------------
// Keyed detection table ranker datapath
// Entry memories, sequential key and strength scan, and the result register.
// ----------------------------------------------------------------------------
module kdtr_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  kdtr_pkg::t_dp_cmd        i_cmd_bus,
    output kdtr_pkg::t_dp_sts        o_sts,
    input  logic [1:0]               i_cmd,
    input  logic [47:0]              i_mac,
    input  logic [7:0]               i_channel,
    input  logic signed [7:0]        i_rssi,
    input  logic [1:0]               i_det_type,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_kind,
    output logic [2:0]               o_status,
    output logic [47:0]              o_entry_mac,
    output logic [7:0]               o_entry_channel,
    output logic signed [7:0]        o_entry_rssi,
    output logic [1:0]               o_entry_det,
    output logic [5:0]               o_rank,
    output logic [6:0]               o_entry_total,
    output logic                     o_last
);
    import kdtr_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [MAC_W-1:0]         mem_mac  [CAPACITY];
    logic signed [RSSI_W-1:0] mem_rssi [CAPACITY];
    logic [CH_W-1:0]          mem_ch   [CAPACITY];
    logic [DET_W-1:0]         mem_det  [CAPACITY];

    logic [MAC_W-1:0]         r_key_mac;
    logic [CH_W-1:0]          r_key_ch;
    logic signed [RSSI_W-1:0] r_key_rssi;
    logic [DET_W-1:0]         r_key_det;
    logic                     r_list;

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_scan_addr;
    logic                     r_pend;
    logic [IW-1:0]            r_pend_idx;
    logic                     r_fnd;
    logic [IW-1:0]            r_fnd_idx;
    logic signed [RSSI_W-1:0] r_fnd_rssi;
    logic                     r_first;
    logic [IW-1:0]            r_prev_idx;
    logic signed [RSSI_W-1:0] r_prev_rssi;
    logic [CW-1:0]            r_rank;

    logic [MAC_W-1:0]         r_rd_mac;
    logic signed [RSSI_W-1:0] r_rd_rssi;
    logic [CH_W-1:0]          r_rd_ch;
    logic [DET_W-1:0]         r_rd_det;

    logic                     r_out_valid;
    logic                     r_out_kind;
    logic [STAT_W-1:0]        r_out_status;
    logic [MAC_W-1:0]         r_out_mac;
    logic [CH_W-1:0]          r_out_ch;
    logic signed [RSSI_W-1:0] r_out_rssi;
    logic [DET_W-1:0]         r_out_det;
    logic [RANK_W-1:0]        r_out_rank;
    logic [TOTAL_W-1:0]       r_out_total;
    logic                     r_out_last;

    logic                     n_kind;
    logic [STAT_W-1:0]        n_status;
    logic [MAC_W-1:0]         n_mac;
    logic [CH_W-1:0]          n_ch;
    logic signed [RSSI_W-1:0] n_rssi;
    logic [DET_W-1:0]         n_det;
    logic [RANK_W-1:0]        n_rank;
    logic [TOTAL_W-1:0]       n_total;
    logic                     n_last;

    logic [IW-1:0]            rd_addr;
    logic                     is_after;
    logic                     take;
    logic                     full;
    logic                     last_rank;
    logic signed [RSSI_W-1:0] upd_rssi;
    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    logic signed [RSSI_W-1:0] wr_rssi;
    logic                     emit_any;
    logic                     out_free;

    assign rd_addr   = i_cmd_bus.scan_step ? r_scan_addr[IW-1:0] : r_fnd_idx;
    assign full      = (r_count == CW'(CAPACITY));
    assign last_rank = ((r_rank + CW'(1)) == r_count);
    assign upd_rssi  = (r_key_rssi > r_fnd_rssi) ? r_key_rssi : r_fnd_rssi;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_any  = i_cmd_bus.emit_report || i_cmd_bus.emit_clear ||
                       i_cmd_bus.emit_empty || i_cmd_bus.emit_entry;

    // An entry follows the previous pick when it is weaker, or equally strong
    // and stored later; the strongest such entry, earliest first, is kept.
    assign is_after = r_first || (r_rd_rssi < r_prev_rssi) ||
                      ((r_rd_rssi == r_prev_rssi) && (r_pend_idx > r_prev_idx));
    always_comb begin
        if (r_list) begin
            take = r_pend && is_after && (!r_fnd || (r_rd_rssi > r_fnd_rssi));
        end else begin
            take = r_pend && !r_fnd && (r_rd_mac == r_key_mac);
        end
    end

    assign wr_en   = i_cmd_bus.emit_report && (r_fnd || !full);
    assign wr_addr = r_fnd ? r_fnd_idx : r_count[IW-1:0];
    assign wr_rssi = r_fnd ? upd_rssi : r_key_rssi;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_mac[wr_addr]  <= r_key_mac;
            mem_rssi[wr_addr] <= wr_rssi;
            mem_ch[wr_addr]   <= r_key_ch;
            mem_det[wr_addr]  <= r_key_det;
        end
        r_rd_mac  <= mem_mac[rd_addr];
        r_rd_rssi <= mem_rssi[rd_addr];
        r_rd_ch   <= mem_ch[rd_addr];
        r_rd_det  <= mem_det[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load_item) begin
            r_key_mac  <= i_mac;
            r_key_ch   <= i_channel;
            r_key_rssi <= i_rssi;
            r_key_det  <= i_det_type;
            r_list     <= (i_cmd == CMD_LIST);
            r_first    <= 1'b1;
            r_rank     <= '0;
        end else if (i_cmd_bus.next_rank) begin
            r_first     <= 1'b0;
            r_prev_idx  <= r_fnd_idx;
            r_prev_rssi <= r_fnd_rssi;
            r_rank      <= r_rank + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_fnd  <= 1'b0;
        end else if (i_cmd_bus.scan_start) begin
            r_scan_addr <= '0;
            r_pend      <= 1'b0;
            r_fnd       <= 1'b0;
        end else if (i_cmd_bus.scan_step) begin
            if (r_scan_addr < r_count) begin
                r_pend      <= 1'b1;
                r_pend_idx  <= r_scan_addr[IW-1:0];
                r_scan_addr <= r_scan_addr + CW'(1);
            end else begin
                r_pend <= 1'b0;
            end
            if (take) begin
                r_fnd      <= 1'b1;
                r_fnd_idx  <= r_pend_idx;
                r_fnd_rssi <= r_rd_rssi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd_bus.emit_clear) begin
            r_count <= '0;
        end else if (i_cmd_bus.emit_report && !r_fnd && !full) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_comb begin
        n_kind   = KIND_STATUS;
        n_status = ST_INSERTED;
        n_mac    = '0;
        n_ch     = '0;
        n_rssi   = '0;
        n_det    = '0;
        n_rank   = '0;
        n_total  = '0;
        n_last   = 1'b1;
        if (i_cmd_bus.emit_report) begin
            n_mac = r_key_mac;
            n_ch  = r_key_ch;
            n_det = r_key_det;
            if (r_fnd) begin
                n_status = ST_UPDATED;
                n_rssi   = upd_rssi;
                n_total  = TOTAL_W'(r_count);
            end else if (full) begin
                n_status = ST_DROPPED;
                n_rssi   = r_key_rssi;
                n_total  = TOTAL_W'(r_count);
            end else begin
                n_status = ST_INSERTED;
                n_rssi   = r_key_rssi;
                n_total  = TOTAL_W'(r_count) + TOTAL_W'(1);
            end
        end else if (i_cmd_bus.emit_clear) begin
            n_status = ST_CLEARED;
        end else if (i_cmd_bus.emit_empty) begin
            n_status = ST_EMPTY;
        end else if (i_cmd_bus.emit_entry) begin
            n_kind  = KIND_ENTRY;
            n_mac   = r_rd_mac;
            n_ch    = r_rd_ch;
            n_rssi  = r_rd_rssi;
            n_det   = r_rd_det;
            n_rank  = RANK_W'(r_rank);
            n_total = TOTAL_W'(r_count);
            n_last  = last_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_any) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_any) begin
            r_out_kind   <= n_kind;
            r_out_status <= n_status;
            r_out_mac    <= n_mac;
            r_out_ch     <= n_ch;
            r_out_rssi   <= n_rssi;
            r_out_det    <= n_det;
            r_out_rank   <= n_rank;
            r_out_total  <= n_total;
            r_out_last   <= n_last;
        end
    end

    assign o_sts.scan_done   = !r_pend && (r_scan_addr >= r_count);
    assign o_sts.mode_list   = r_list;
    assign o_sts.table_empty = (r_count == '0);
    assign o_sts.last_rank   = last_rank;
    assign o_sts.out_free    = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_status        = r_out_status;
    assign o_entry_mac     = r_out_mac;
    assign o_entry_channel = r_out_ch;
    assign o_entry_rssi    = r_out_rssi;
    assign o_entry_det     = r_out_det;
    assign o_rank          = r_out_rank;
    assign o_entry_total   = r_out_total;
    assign o_last          = r_out_last;

endmodule

// ===== rtl/keyed_detection_table_ranker.sv =====
// ----------------------------------------------------------------------------
// Keyed detection table ranker
// Table of detected transmitters keyed by MAC, with strongest-first listing.
// ----------------------------------------------------------------------------
// Entries live in memories with a registered read, so every lookup walks
// the table one entry per cycle. A list picks each entry in rank order by a
// full walk of the table. A new request is taken while the last result
// still waits in the output register.
module keyed_detection_table_ranker #(
    parameter int CAPACITY = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_cmd,
    input  logic [47:0]       i_mac,
    input  logic [7:0]        i_channel,
    input  logic signed [7:0] i_rssi,
    input  logic [1:0]        i_det_type,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_kind,
    output logic [2:0]        o_status,
    output logic [47:0]       o_entry_mac,
    output logic [7:0]        o_entry_channel,
    output logic signed [7:0] o_entry_rssi,
    output logic [1:0]        o_entry_det,
    output logic [5:0]        o_rank,
    output logic [6:0]        o_entry_total,
    output logic              o_last
);
    import kdtr_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    kdtr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    kdtr_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_bus       (dp_cmd),
        .o_sts           (dp_sts),
        .i_cmd           (i_cmd),
        .i_mac           (i_mac),
        .i_channel       (i_channel),
        .i_rssi          (i_rssi),
        .i_det_type      (i_det_type),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_status        (o_status),
        .o_entry_mac     (o_entry_mac),
        .o_entry_channel (o_entry_channel),
        .o_entry_rssi    (o_entry_rssi),
        .o_entry_det     (o_entry_det),
        .o_rank          (o_rank),
        .o_entry_total   (o_entry_total),
        .o_last          (o_last)
    );

    // A list still in progress must keep new requests out.
    a_list_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_ENTRY) && !o_last) |-> o_in_stall)
        else $error("request taken while a list was unfinished");

    a_entry_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_ENTRY)) |->
            ((o_status == ST_INSERTED) && ({1'b0, o_rank} < o_entry_total)))
        else $error("listed entry has a bad rank or status");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_STATUS)) |-> o_last)
        else $error("status result without last mark");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_total <= 7'(CAPACITY)))
        else $error("entry total beyond capacity");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Keyed detection table ranker testbench
// Sends report, clear, list and unused-code requests through the valid/stall
// handshake and keeps its own copy of the transmitter table to predict every
// result. Each result is checked field by field. The run goes through phases
// with no idling, with sender gaps, with receiver stalls, and with both.
// ----------------------------------------------------------------------------
module testbench;
    import kdtr_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [MAC_W-1:0]  mac;
        logic [CH_W-1:0]   channel;
        logic [RSSI_W-1:0] rssi;
        logic [DET_W-1:0]  det;
    } t_request;

    typedef struct packed {
        logic               kind;
        logic [STAT_W-1:0]  status;
        logic [MAC_W-1:0]   mac;
        logic [CH_W-1:0]    channel;
        logic [RSSI_W-1:0]  rssi;
        logic [DET_W-1:0]   det;
        logic [RANK_W-1:0]  rank;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_cmd;
    logic [47:0]       i_mac;
    logic [7:0]        i_channel;
    logic signed [7:0] i_rssi;
    logic [1:0]        i_det_type;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_kind;
    logic [2:0]        o_status;
    logic [47:0]       o_entry_mac;
    logic [7:0]        o_entry_channel;
    logic signed [7:0] o_entry_rssi;
    logic [1:0]        o_entry_det;
    logic [5:0]        o_rank;
    logic [6:0]        o_entry_total;
    logic              o_last;

    keyed_detection_table_ranker #(
        .CAPACITY(TABLE_DEPTH)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_cmd(i_cmd),
        .i_mac(i_mac),
        .i_channel(i_channel),
        .i_rssi(i_rssi),
        .i_det_type(i_det_type),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_kind(o_kind),
        .o_status(o_status),
        .o_entry_mac(o_entry_mac),
        .o_entry_channel(o_entry_channel),
        .o_entry_rssi(o_entry_rssi),
        .o_entry_det(o_entry_det),
        .o_rank(o_rank),
        .o_entry_total(o_entry_total),
        .o_last(o_last)
    );

    t_request pending_requests[$];
    t_result  expected_results[$];
    logic [MAC_W-1:0] mac_pool[$];

    logic [MAC_W-1:0]         tbl_mac[TABLE_DEPTH];
    logic signed [RSSI_W-1:0] tbl_rssi[TABLE_DEPTH];
    logic [CH_W-1:0]          tbl_channel[TABLE_DEPTH];
    logic [DET_W-1:0]         tbl_det[TABLE_DEPTH];
    int tbl_count = 0;

    int send_idle_by_phase[4] = '{0, 77, 0, 20};
    int recv_stall_by_phase[4] = '{0, 0, 77, 20};
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int phase_items = 0;

    logic     req_taken = 1'b0;
    t_request next_req;
    t_request taken_req;
    t_result  seen_result;

    int cycles = 0;
    int mismatches = 0;
    int n_requests = 0;
    int n_checked = 0;
    int n_inserts = 0;
    int n_updates = 0;
    int n_drops = 0;
    int n_listed = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        end
    endtask

    task automatic push_result(logic kind, logic [STAT_W-1:0] status,
                               logic [MAC_W-1:0] mac, logic [CH_W-1:0] channel,
                               logic [RSSI_W-1:0] rssi, logic [DET_W-1:0] det,
                               logic [RANK_W-1:0] rank, logic [TOTAL_W-1:0] total,
                               logic last);
        t_result r;
        r.kind = kind;
        r.status = status;
        r.mac = mac;
        r.channel = channel;
        r.rssi = rssi;
        r.det = det;
        r.rank = rank;
        r.total = total;
        r.last = last;
        expected_results.push_back(r);
    endtask

    task automatic predict_table_request(t_request r);
        int hit;
        int i;
        int j;
        int v;
        int ord[TABLE_DEPTH];
        hit = -1;
        case (r.cmd)
            CMD_REPORT: begin
                for (i = 0; i < tbl_count; i++) begin
                    if (hit < 0 && tbl_mac[i] == r.mac) hit = i;
                end
                if (hit >= 0) begin
                    if ($signed(r.rssi) > tbl_rssi[hit]) tbl_rssi[hit] = r.rssi;
                    tbl_channel[hit] = r.channel;
                    tbl_det[hit] = r.det;
                    push_result(KIND_STATUS, ST_UPDATED, r.mac, r.channel, tbl_rssi[hit],
                                r.det, '0, TOTAL_W'(tbl_count), 1'b1);
                    n_updates++;
                end else if (tbl_count >= TABLE_DEPTH) begin
                    push_result(KIND_STATUS, ST_DROPPED, r.mac, r.channel, r.rssi, r.det,
                                '0, TOTAL_W'(tbl_count), 1'b1);
                    n_drops++;
                end else begin
                    tbl_mac[tbl_count] = r.mac;
                    tbl_rssi[tbl_count] = r.rssi;
                    tbl_channel[tbl_count] = r.channel;
                    tbl_det[tbl_count] = r.det;
                    tbl_count++;
                    push_result(KIND_STATUS, ST_INSERTED, r.mac, r.channel, r.rssi, r.det,
                                '0, TOTAL_W'(tbl_count), 1'b1);
                    n_inserts++;
                end
            end
            CMD_CLEAR: begin
                tbl_count = 0;
                push_result(KIND_STATUS, ST_CLEARED, '0, '0, '0, '0, '0, '0, 1'b1);
            end
            CMD_LIST: begin
                if (tbl_count == 0) begin
                    push_result(KIND_STATUS, ST_EMPTY, '0, '0, '0, '0, '0, '0, 1'b1);
                end else begin
                    for (i = 0; i < tbl_count; i++) ord[i] = i;
                    // Stable insertion sort: equal strengths keep insertion order.
                    for (i = 1; i < tbl_count; i++) begin
                        v = ord[i];
                        j = i;
                        while (j > 0 && tbl_rssi[ord[j-1]] < tbl_rssi[v]) begin
                            ord[j] = ord[j-1];
                            j--;
                        end
                        ord[j] = v;
                    end
                    for (i = 0; i < tbl_count; i++) begin
                        push_result(KIND_ENTRY, ST_INSERTED, tbl_mac[ord[i]],
                                    tbl_channel[ord[i]], tbl_rssi[ord[i]], tbl_det[ord[i]],
                                    RANK_W'(i), TOTAL_W'(tbl_count), i == tbl_count - 1);
                    end
                    n_listed += tbl_count;
                end
            end
            default: begin
            end
        endcase
        if (r.cmd != CMD_UNUSED) n_requests++;
    endtask

    task automatic check_result(t_result got);
        t_result want;
        n_checked++;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected, status", 64'(got.status), 64'd0);
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind) begin
            report_mismatch("kind", 64'(got.kind), 64'(want.kind));
        end
        if (got.status !== want.status) begin
            report_mismatch("status", 64'(got.status), 64'(want.status));
        end
        if (got.mac !== want.mac) begin
            report_mismatch("entry_mac", 64'(got.mac), 64'(want.mac));
        end
        if (got.channel !== want.channel) begin
            report_mismatch("entry_channel", 64'(got.channel), 64'(want.channel));
        end
        if (got.rssi !== want.rssi) begin
            report_mismatch("entry_rssi", 64'(got.rssi), 64'(want.rssi));
        end
        if (got.det !== want.det) begin
            report_mismatch("entry_det", 64'(got.det), 64'(want.det));
        end
        if (got.rank !== want.rank) begin
            report_mismatch("rank", 64'(got.rank), 64'(want.rank));
        end
        if (got.total !== want.total) begin
            report_mismatch("entry_total", 64'(got.total), 64'(want.total));
        end
        if (got.last !== want.last) begin
            report_mismatch("last", 64'(got.last), 64'(want.last));
        end
    endtask

    task automatic add_request(logic [CMD_W-1:0] cmd, logic [MAC_W-1:0] mac,
                               logic [CH_W-1:0] channel, logic [RSSI_W-1:0] rssi,
                               logic [DET_W-1:0] det);
        t_request r;
        r.cmd = cmd;
        r.mac = mac;
        r.channel = channel;
        r.rssi = rssi;
        r.det = det;
        pending_requests.push_back(r);
        if (cmd != CMD_UNUSED) phase_items++;
    endtask

    function automatic logic [MAC_W-1:0] random_mac();
        logic [MAC_W-1:0] m;
        m[47:32] = 16'($urandom_range(16'hFFFF));
        m[31:0] = $urandom();
        return m;
    endfunction

    // Half the strengths fall in a narrow band so that ties are common.
    function automatic logic [RSSI_W-1:0] random_rssi();
        logic [RSSI_W-1:0] s;
        if ($urandom_range(1) == 1) s = RSSI_W'($urandom_range(255));
        else s = RSSI_W'(-60 + $urandom_range(3));
        return s;
    endfunction

    task automatic add_filler(logic [CMD_W-1:0] cmd);
        add_request(cmd, random_mac(), CH_W'($urandom_range(255)),
                    RSSI_W'($urandom_range(255)), DET_W'($urandom_range(3)));
    endtask

    task automatic add_report(int reuse_pct);
        logic [MAC_W-1:0] m;
        int pick;
        pick = $urandom_range(99);
        if (mac_pool.size() != 0 && pick < reuse_pct) begin
            m = mac_pool[$urandom_range(mac_pool.size() - 1)];
        end else if (mac_pool.size() != 0 && pick < reuse_pct + 10) begin
            m = mac_pool[$urandom_range(mac_pool.size() - 1)] ^ (48'd1 << $urandom_range(47));
            mac_pool.push_back(m);
        end else begin
            m = random_mac();
            mac_pool.push_back(m);
        end
        add_request(CMD_REPORT, m, CH_W'($urandom_range(255)), random_rssi(),
                    DET_W'($urandom_range(3)));
    endtask

    task automatic add_sequence();
        int n_reports;
        int reuse_pct;
        int i;
        logic big;
        big = ($urandom_range(11) == 0);
        n_reports = big ? $urandom_range(80, 70) : $urandom_range(12, 1);
        reuse_pct = big ? 2 : 35;
        mac_pool.delete();
        add_filler(CMD_CLEAR);
        for (i = 0; i < n_reports; i++) begin
            add_report(reuse_pct);
            if (!big && $urandom_range(15) == 0) begin
                add_filler(CMD_LIST);
            end
        end
        add_filler(CMD_LIST);
    endtask

    task automatic add_noise();
        logic [CMD_W-1:0] cmd;
        logic [MAC_W-1:0] m;
        cmd = CMD_W'($urandom_range(3));
        if (mac_pool.size() != 0 && $urandom_range(1) == 1) begin
            m = mac_pool[$urandom_range(mac_pool.size() - 1)];
        end else begin
            m = random_mac();
        end
        add_request(cmd, m, CH_W'($urandom_range(255)), RSSI_W'($urandom_range(255)),
                    DET_W'($urandom_range(3)));
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || req_taken) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_requests.pop_front();
                    i_cmd <= next_req.cmd;
                    i_mac <= next_req.mac;
                    i_channel <= next_req.channel;
                    i_rssi <= next_req.rssi;
                    i_det_type <= next_req.det;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                taken_req.cmd = i_cmd;
                taken_req.mac = i_mac;
                taken_req.channel = i_channel;
                taken_req.rssi = i_rssi;
                taken_req.det = i_det_type;
                predict_table_request(taken_req);
            end
            if (o_out_valid && !i_out_stall) begin
                seen_result.kind = o_kind;
                seen_result.status = o_status;
                seen_result.mac = o_entry_mac;
                seen_result.channel = o_entry_channel;
                seen_result.rssi = o_entry_rssi;
                seen_result.det = o_entry_det;
                seen_result.rank = o_rank;
                seen_result.total = o_entry_total;
                seen_result.last = o_last;
                check_result(seen_result);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int phase;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_cmd = CMD_REPORT;
        i_mac = '0;
        i_channel = '0;
        i_rssi = '0;
        i_det_type = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_request(CMD_LIST, '0, '0, '0, '0);
        add_request(CMD_REPORT, 48'h0000_0000_0000, 8'd0, RSSI_W'(-128), 2'd0);
        add_request(CMD_REPORT, 48'hFFFF_FFFF_FFFF, 8'd255, RSSI_W'(127), 2'd3);
        add_request(CMD_REPORT, 48'h0000_0000_0001, 8'd1, RSSI_W'(-128), 2'd1);
        add_request(CMD_REPORT, 48'h0000_0000_0000, 8'd7, RSSI_W'(-100), 2'd2);
        add_request(CMD_REPORT, 48'hFFFF_FFFF_FFFF, 8'd9, RSSI_W'(-5), 2'd0);
        add_request(CMD_REPORT, 48'h8000_0000_0000, 8'd128, RSSI_W'(-100), 2'd2);
        add_request(CMD_REPORT, 48'h0000_0000_0001, 8'd3, RSSI_W'(-128), 2'd3);
        add_request(CMD_UNUSED, 48'hFFFF_FFFF_FFFF, 8'd255, RSSI_W'(-1), 2'd3);
        add_request(CMD_LIST, 48'hFFFF_FFFF_FFFF, 8'd255, RSSI_W'(-1), 2'd3);
        add_request(CMD_CLEAR, 48'hFFFF_FFFF_FFFF, 8'd255, RSSI_W'(-1), 2'd3);
        add_request(CMD_LIST, '0, '0, '0, '0);
        add_request(CMD_CLEAR, '0, '0, '0, '0);
        add_request(CMD_REPORT, 48'hA5A5_5A5A_F00F, 8'd128, RSSI_W'(0), 2'd1);
        add_request(CMD_REPORT, 48'h5A5A_A5A5_0FF0, 8'd127, RSSI_W'(-1), 2'd2);
        add_request(CMD_REPORT, 48'h1234_5678_9ABC, 8'd64, RSSI_W'(0), 2'd0);
        add_request(CMD_LIST, '0, '0, '0, '0);

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = send_idle_by_phase[phase];
            recv_stall_pct = recv_stall_by_phase[phase];
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                if ($urandom_range(3) == 0) add_noise();
                else add_sequence();
            end
            while (pending_requests.size() != 0) @(posedge i_clk);
        end

        while (pending_requests.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d inserts, %0d updates, %0d drops on a full table,",
                 n_requests, n_inserts, n_updates, n_drops);
        $display("and %0d listed entries among %0d results checked, over four idling phases.",
                 n_listed, n_checked);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
